FILE: rtl/sliding_window_median_defines.svh
// Assertion macros used by the checker file.
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

// Same-cycle implication under active-low reset.
`define SWM_ASSERT_NOW(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("sliding_window_median check failed");

// Next-cycle implication under active-low reset.
`define SWM_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("sliding_window_median check failed");

`endif

FILE: rtl/swm_pkg.sv
// Shared types for the sliding window median filter.
package swm_pkg;

  typedef struct packed {
    logic del_seen;
    logic gt;
  } swm_link_t;

endpackage

FILE: rtl/swm_cell.sv
// One cell of the sorted window chain: a sample and its age.
module swm_cell #(
  parameter int SampleBits = 16,
  parameter int AgeBits    = 3,
  parameter int Window     = 5,
  parameter int Index      = 0,
  parameter bit IsLast     = 1'b0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic signed [SampleBits-1:0] x_i,
  input  swm_pkg::swm_link_t           left_link_i,
  input  logic signed [SampleBits-1:0] left_val_i,
  input  logic        [AgeBits-1:0]    left_age_i,
  input  logic signed [SampleBits-1:0] nxt_val_i,
  input  logic        [AgeBits-1:0]    nxt_age_i,
  output logic signed [SampleBits-1:0] val_o,
  output logic        [AgeBits-1:0]    age_o,
  output swm_pkg::swm_link_t           right_link_o,
  output logic signed [SampleBits-1:0] r_val_o,
  output logic        [AgeBits-1:0]    r_age_o,
  output logic signed [SampleBits-1:0] val_d_o
);

  logic signed [SampleBits-1:0] val_q, val_d;
  logic        [AgeBits-1:0]    age_q, age_d;
  logic                         del;
  logic                         shift;
  logic                         gt;

  assign del     = (age_q == AgeBits'(Window - 1));
  assign shift   = left_link_i.del_seen | del;
  assign r_val_o = shift ? nxt_val_i : val_q;
  assign r_age_o = shift ? nxt_age_i : age_q;
  assign gt      = IsLast ? 1'b1 : (r_val_o > x_i);

  assign right_link_o = '{del_seen: shift, gt: gt};

  always_comb begin
    if (left_link_i.gt) begin
      val_d = left_val_i;
      age_d = left_age_i + AgeBits'(1);
    end else if (gt) begin
      val_d = x_i;
      age_d = '0;
    end else begin
      val_d = r_val_o;
      age_d = r_age_o + AgeBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      age_q <= AgeBits'(Index);
    end else if (en_i) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign val_o   = val_q;
  assign age_o   = age_q;
  assign val_d_o = val_d;

endmodule

FILE: rtl/sliding_window_median.sv
// Top level of the sliding window median filter.
// Output: the median of an accepted request is in the output register in the next cycle.
// Throughput: 1 request per cycle while in_stall_o is low; the whole cell row updates
// together, with the deleted-entry flag rippling combinationally through the cells.
// Reset: window holds WINDOW zeros, cell ages 0..WINDOW-1, output register empty.
module sliding_window_median #(
  parameter int WINDOW      = 5,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] median_o
);

  localparam int AgeBits = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int MidIdx  = WINDOW / 2;

  swm_pkg::swm_link_t           rlink [WINDOW];
  swm_pkg::swm_link_t           llink [WINDOW];
  logic signed [SAMPLE_BITS-1:0] val   [WINDOW];
  logic        [AgeBits-1:0]     age   [WINDOW];
  logic signed [SAMPLE_BITS-1:0] r_val [WINDOW];
  logic        [AgeBits-1:0]     r_age [WINDOW];
  logic signed [SAMPLE_BITS-1:0] l_val [WINDOW];
  logic        [AgeBits-1:0]     l_age [WINDOW];
  logic signed [SAMPLE_BITS-1:0] n_val [WINDOW];
  logic        [AgeBits-1:0]     n_age [WINDOW];
  logic signed [SAMPLE_BITS-1:0] val_d [WINDOW];

  logic                          accept;
  logic                          out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] median_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign llink[i] = '{del_seen: 1'b0, gt: 1'b0};
      assign l_val[i] = '0;
      assign l_age[i] = '0;
    end else begin : g_mid
      assign llink[i] = rlink[i-1];
      assign l_val[i] = r_val[i-1];
      assign l_age[i] = r_age[i-1];
    end
    if (i == WINDOW - 1) begin : g_tail
      assign n_val[i] = val[i];
      assign n_age[i] = age[i];
    end else begin : g_body
      assign n_val[i] = val[i+1];
      assign n_age[i] = age[i+1];
    end

    swm_cell #(
      .SampleBits(SAMPLE_BITS),
      .AgeBits   (AgeBits),
      .Window    (WINDOW),
      .Index     (i),
      .IsLast    (i == WINDOW - 1)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (accept),
      .x_i         (sample_i),
      .left_link_i (llink[i]),
      .left_val_i  (l_val[i]),
      .left_age_i  (l_age[i]),
      .nxt_val_i   (n_val[i]),
      .nxt_age_i   (n_age[i]),
      .val_o       (val[i]),
      .age_o       (age[i]),
      .right_link_o(rlink[i]),
      .r_val_o     (r_val[i]),
      .r_age_o     (r_age[i]),
      .val_d_o     (val_d[i])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      median_q <= val_d[MidIdx];
    end
  end

  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;

endmodule

FILE: rtl/swm_checker.sv
// Port-level checks for the sliding window median filter, bound to the top level.
`include "sliding_window_median_defines.svh"

module swm_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic signed [SAMPLE_BITS-1:0] sample_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [SAMPLE_BITS-1:0] median_o
);

  logic in_acc;
  logic in_held;
  logic out_held;

  assign in_acc   = in_valid_i & ~in_stall_o;
  assign in_held  = in_valid_i & in_stall_o;
  assign out_held = out_valid_o & out_stall_i;

  `SWM_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_held, in_valid_i && $stable(sample_i))
  `SWM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(median_o))
  `SWM_ASSERT_NEXT(a_req_gives_result, clk_i, rst_ni, in_acc, out_valid_o)
  `SWM_ASSERT_NEXT(a_no_phantom, clk_i, rst_ni, !in_acc && !out_held, !out_valid_o)
  `SWM_ASSERT_NOW(a_stall_when_full, clk_i, rst_ni, out_held, in_stall_o)

endmodule

bind sliding_window_median swm_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_swm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .sample_i   (sample_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .median_o   (median_o)
);

FILE: tb/tb_sliding_window_median.sv
// Self-checking testbench for the sliding window median filter.
`timescale 1ns / 1ps

module tb_sliding_window_median;

  localparam int WINDOW         = 5;
  localparam int SAMPLE_BITS    = 16;
  localparam int RESET_CYCLES   = 6;
  localparam int PHASE_ITEMS    = 150;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  class median_scoreboard;
    sample_t window_samples [WINDOW];
    int      oldest_idx;
    sample_t expected_medians [$];
    int      mismatch_count;

    function new();
      foreach (window_samples[k]) window_samples[k] = '0;
      oldest_idx     = 0;
      mismatch_count = 0;
    endfunction

    function void note_sample(sample_t s);
      sample_t sorted [WINDOW];
      sample_t v;
      int      j;
      window_samples[oldest_idx] = s;
      oldest_idx = (oldest_idx == WINDOW - 1) ? 0 : oldest_idx + 1;
      for (int i = 0; i < WINDOW; i++) begin
        v = window_samples[i];
        j = i;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      expected_medians.push_back(sorted[WINDOW/2]);
    endfunction

    function void check_median(sample_t m);
      sample_t exp_m;
      if (expected_medians.size() == 0) begin
        $display("%0t: unexpected median %0d", $time, m);
        mismatch_count++;
      end else begin
        exp_m = expected_medians.pop_front();
        if (m !== exp_m) begin
          $display("%0t: median expected %0d, got %0d", $time, exp_m, m);
          mismatch_count++;
        end
      end
    endfunction

    function int pending();
      return expected_medians.size();
    endfunction
  endclass

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    in_valid_i;
  logic    in_stall_o;
  sample_t sample_i;
  logic    out_valid_o;
  logic    out_stall_i;
  sample_t median_o;

  median_scoreboard sb;
  int snd_idle_pct;
  int rcv_idle_pct;
  bit hold_off_req = 1'b0;
  int quiet_cycles = 0;

  sample_t directed_samples [$] = '{
    16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
    16'sh8000, 16'sh8000, -16'sd1, 16'sd1, 16'sd0, 16'sd5, 16'sd5,
    16'sd5, -16'sd5, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd4,
    16'sd3, 16'sd2, 16'sh7fff
  };

  sliding_window_median #(
    .WINDOW     (WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .median_o   (median_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic sample_t random_sample();
    case ($urandom_range(0, 7))
      0, 1:    return sample_t'($urandom_range(0, 4) - 2);
      2:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_sample(sample_t s);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // receiver side: random stall, plus one long hold-off on request
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (in_valid_i && !in_stall_o) sb.note_sample(sample_i);
      if (out_valid_o && !out_stall_i) sb.check_median(median_o);
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    snd_idle_pct = 19;
    rcv_idle_pct = 60;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    sample_i   <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_samples[k]) send_sample(directed_samples[k]);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          snd_idle_pct = 19;
          rcv_idle_pct = 60;
        end
        1: begin
          snd_idle_pct = 60;
          rcv_idle_pct = 19;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
          hold_off_req = 1'b1;
        end
      endcase
      repeat (PHASE_ITEMS) send_sample(random_sample());
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
